// ----- rtl/fir41_pkg.sv -----
// ----------------------------------------------------------------------------
// fir41_pkg
// Shared widths and the symmetric coefficient table of the 41-tap low-pass FIR.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fir41_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int OUT_BITS      = 17;
    localparam int OUTPUT_SHIFT  = 8;
    localparam int COEF_BITS     = 6;
    localparam int COEF_LEN      = 41;
    localparam int COEF_IDX_BITS = 7;
    localparam int PROD_BITS     = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS      = PROD_BITS + 6;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;

    localparam coef_t COEF_TABLE [COEF_LEN] = '{
        6'sd0,  6'sd0,  6'sd0,  -6'sd1, -6'sd1, -6'sd1, -6'sd1, -6'sd2, -6'sd2, -6'sd1,
        6'sd0,  6'sd2,  6'sd4,  6'sd7,  6'sd10, 6'sd14, 6'sd18, 6'sd21, 6'sd23, 6'sd25,
        6'sd25,
        6'sd25, 6'sd23, 6'sd21, 6'sd18, 6'sd14, 6'sd10, 6'sd7,  6'sd4,  6'sd2,  6'sd0,
        -6'sd1, -6'sd2, -6'sd2, -6'sd1, -6'sd1, -6'sd1, -6'sd1, 6'sd0,  6'sd0,  6'sd0
    };

    // Taps beyond the table weigh zero.
    function automatic coef_t coef_at(input logic [COEF_IDX_BITS-1:0] idx);
        coef_t c;
        c = '0;
        if (idx < COEF_IDX_BITS'(COEF_LEN)) begin
            c = COEF_TABLE[idx[5:0]];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fir41_ram.sv -----
// ----------------------------------------------------------------------------
// fir41_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fir41_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 41
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/fir_lowpass_41_tap_core.sv -----
// ----------------------------------------------------------------------------
// fir_lowpass_41_tap_core
// 41-tap symmetric integer low-pass FIR with one shared multiply-accumulate.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+--------------------------------
//   s_      | in        | s_valid/s_ready  | s_sample_in    signed 16 bits
//   m_      | out       | m_valid/m_ready  | m_filtered_out signed 17 bits
//
// One transaction steps from accept through ST_WRITE, ST_MAC, ST_DRAIN and ST_OUT
// to its result; the single multiplier takes one delay-line RAM read a cycle in ST_MAC.
// s_ready is high only while the sequencer is idle; a result may wait in the
// output register while the next transaction is accepted.
// Reset (aresetn, synchronous) clears the delay-line valid bits, so unwritten
// taps read as zero; the write slot returns to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fir_lowpass_41_tap_core
    import fir41_pkg::*;
#(
    parameter int TAP_COUNT = 41
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample_in,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [OUT_BITS-1:0]       m_filtered_out
);

    localparam int TAP_W = $clog2(TAP_COUNT);
    localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAP_COUNT - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WRITE = 5'b00010,
        ST_MAC   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t                   state_reg, state_next;
    sample_t                  sample_reg, sample_next;
    logic [TAP_W-1:0]         slot_reg, slot_next;
    logic [TAP_W-1:0]         rd_idx_reg, rd_idx_next;
    logic [TAP_W-1:0]         iss_cnt_reg, iss_cnt_next;
    logic [TAP_W-1:0]         tap1_reg, tap1_next;
    logic                     rd_pend_reg, rd_pend_next;
    logic                     rd_ok_reg, rd_ok_next;
    logic                     prod_vld_reg, prod_vld_next;
    prod_t                    prod_reg, prod_next;
    acc_t                     acc_reg, acc_next;
    logic [TAP_COUNT-1:0]     valid_reg, valid_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [OUT_BITS-1:0] out_reg, out_next;

    logic                     ram_wr_en;
    logic [SAMPLE_BITS-1:0]   ram_rd_data;
    sample_t                  tap_sample;
    acc_t                     acc_shift;

    fir41_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TAP_COUNT)
    ) u_delay_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (sample_reg),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rd_data)
    );

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_filtered_out = out_reg;
    assign ram_wr_en      = (state_reg == ST_WRITE);
    assign tap_sample     = rd_ok_reg ? sample_t'(ram_rd_data) : '0;
    assign acc_shift      = acc_reg >>> OUTPUT_SHIFT;

    always_comb begin
        state_next    = state_reg;
        sample_next   = sample_reg;
        slot_next     = slot_reg;
        rd_idx_next   = rd_idx_reg;
        iss_cnt_next  = iss_cnt_reg;
        tap1_next     = tap1_reg;
        rd_pend_next  = 1'b0;
        rd_ok_next    = rd_ok_reg;
        prod_vld_next = rd_pend_reg;
        prod_next     = tap_sample * coef_at(COEF_IDX_BITS'(tap1_reg));
        acc_next      = acc_reg;
        valid_next    = valid_reg;
        m_valid_next  = m_valid_reg;
        out_next      = out_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (prod_vld_reg) begin
            acc_next = acc_reg + ACC_BITS'(prod_reg);
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    sample_next = s_sample_in;
                    state_next  = ST_WRITE;
                end
            end
            ST_WRITE: begin
                valid_next[slot_reg] = 1'b1;
                rd_idx_next          = slot_reg;
                iss_cnt_next         = '0;
                acc_next             = '0;
                state_next           = ST_MAC;
            end
            ST_MAC: begin
                rd_pend_next = 1'b1;
                rd_ok_next   = valid_reg[rd_idx_reg];
                tap1_next    = iss_cnt_reg;
                rd_idx_next  = (rd_idx_reg == '0) ? LAST_TAP : rd_idx_reg - 1'b1;
                iss_cnt_next = iss_cnt_reg + 1'b1;
                if (iss_cnt_reg == LAST_TAP) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_pend_reg && !prod_vld_reg) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = acc_shift[OUT_BITS-1:0];
                    m_valid_next = 1'b1;
                    slot_next    = (slot_reg == LAST_TAP) ? '0 : slot_reg + 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            slot_reg     <= '0;
            rd_pend_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            rd_pend_reg  <= rd_pend_next;
            prod_vld_reg <= prod_vld_next;
            valid_reg    <= valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg  <= sample_next;
        rd_idx_reg  <= rd_idx_next;
        iss_cnt_reg <= iss_cnt_next;
        tap1_reg    <= tap1_next;
        rd_ok_reg   <= rd_ok_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        out_reg     <= out_next;
    end

`ifndef SYNTHESIS
    a_accept_to_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_WRITE))
        else $error("accepted transaction did not start a delay-line write");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= LAST_TAP)
        else $error("write slot out of range");

    a_mac_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC) |-> (rd_idx_reg <= LAST_TAP))
        else $error("tap read index out of range");

    a_drained_at_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> (!rd_pend_reg && !prod_vld_reg))
        else $error("accumulator pipeline not empty at output");
`endif

endmodule

`default_nettype wire
